[src/smm_pkg.sv]
// Shared types, codes and helpers for the small matrix multiplier.
package smm_pkg;

  // Default largest matrix dimension, and the bound set by the 3-bit index fields.
  localparam int MAX_DIM_DEFAULT = 8;
  localparam int DIM_LIMIT       = 8;

  localparam int DIM_W   = 4;   // width of a size register
  localparam int IDX_W   = 3;   // width of a row or column index
  localparam int ELEM_W  = 32;  // Q16.16 element width
  localparam int PROD_W  = 64;  // full-precision product width
  localparam int FRAC_W  = 16;  // fraction bits
  localparam int CFG_A_W = 2;   // configuration index width

  localparam logic [1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  localparam logic [CFG_A_W-1:0] REG_ROWS_A = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_INNER  = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_COLS_B = 2'd2;

  // Control that travels alongside the operands of one multiply-accumulate step.
  typedef struct packed {
    logic             vld;
    logic             first;    // first term of an element: restart the sum
    logic             lastk;    // final term of an element
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;     // final element of the compute
  } tag_t;

  // One finished product element.
  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [ELEM_W-1:0] value;
    logic              sat;
    logic              last;
  } res_t;

  // A written size of zero becomes one, and a size above the cap becomes the cap.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] cap);
    logic [DIM_W-1:0] x;
    x = v;
    if (x == '0) x = {{(DIM_W-1){1'b0}}, 1'b1};
    if (x > cap) x = cap;
    return x;
  endfunction

endpackage

[src/small_matrix_multiply.sv]
// Small signed Q16.16 matrix multiplier: element stores, sequencer and output register.
//
// Load beats (A or B) are taken one per cycle while in_stall is low and write the
// element store directly; loads outside the configured sizes are dropped. A
// compute beat raises in_stall while the sequencer reads one A and one B element
// per cycle into a single 32x32 multiplier and accumulator; that shared unit sets
// the rate of one product term per cycle unless output stall freezes the whole
// compute pipeline. Each product element passes the read, multiply, accumulate and
// output registers after its last term is read and is emitted in row-major order
// with out_last on the final one. Sums are kept at full precision, shifted right
// by 16 with floor rounding and clipped to 32 bits, with out_saturated marking a
// clip. Store entries hold no reset value and must be loaded before they are used.
module small_matrix_multiply #(
  parameter int MAX_DIM = smm_pkg::MAX_DIM_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [smm_pkg::CFG_A_W-1:0] cfg_addr,
  input  logic [smm_pkg::DIM_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_cmd,
  input  logic [smm_pkg::IDX_W-1:0]   in_elem_row,
  input  logic [smm_pkg::IDX_W-1:0]   in_elem_col,
  input  logic signed [smm_pkg::ELEM_W-1:0] in_elem_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [smm_pkg::IDX_W-1:0]   out_row,
  output logic [smm_pkg::IDX_W-1:0]   out_col,
  output logic signed [smm_pkg::ELEM_W-1:0] out_value,
  output logic                        out_saturated,
  output logic                        out_last
);

  localparam int DIM_CAP = (MAX_DIM < smm_pkg::DIM_LIMIT) ? MAX_DIM : smm_pkg::DIM_LIMIT;
  localparam int DEPTH   = DIM_CAP * DIM_CAP;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW      = 8;
  localparam logic [smm_pkg::DIM_W-1:0] CAP_V = smm_pkg::DIM_W'(DIM_CAP);

  logic [smm_pkg::DIM_W-1:0] rows_a_r, inner_r, cols_b_r;

  logic                      in_acc, load_a, load_b, start;
  logic                      adv, busy;
  logic [FW-1:0]             w_full;
  logic [AW-1:0]             w_addr, a_addr, b_addr;
  smm_pkg::tag_t             seq_tag, tag1_r;
  smm_pkg::res_t             res;

  logic [smm_pkg::ELEM_W-1:0] mem_a [0:DEPTH-1];
  logic [smm_pkg::ELEM_W-1:0] mem_b [0:DEPTH-1];
  logic [smm_pkg::ELEM_W-1:0] a_rd_r, b_rd_r;

  logic                       out_valid_r;
  logic [smm_pkg::IDX_W-1:0]  out_row_r, out_col_r;
  logic [smm_pkg::ELEM_W-1:0] out_value_r;
  logic                       out_sat_r, out_last_r;

  // Size registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= smm_pkg::DIM_W'(1);
      inner_r  <= smm_pkg::DIM_W'(1);
      cols_b_r <= smm_pkg::DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        smm_pkg::REG_ROWS_A: rows_a_r <= smm_pkg::clamp_dim(cfg_wdata, CAP_V);
        smm_pkg::REG_INNER:  inner_r  <= smm_pkg::clamp_dim(cfg_wdata, CAP_V);
        smm_pkg::REG_COLS_B: cols_b_r <= smm_pkg::clamp_dim(cfg_wdata, CAP_V);
        default: ;
      endcase
    end
  end

  assign in_stall = busy;
  assign in_acc   = in_valid && !busy;
  assign load_a   = in_acc && (in_cmd == smm_pkg::CMD_LOAD_A) &&
                    ({1'b0, in_elem_row} < rows_a_r) && ({1'b0, in_elem_col} < inner_r);
  assign load_b   = in_acc && (in_cmd == smm_pkg::CMD_LOAD_B) &&
                    ({1'b0, in_elem_row} < inner_r) && ({1'b0, in_elem_col} < cols_b_r);
  assign start    = in_acc && (in_cmd == smm_pkg::CMD_COMPUTE);

  assign w_full = FW'(in_elem_row) * FW'(DIM_CAP) + FW'(in_elem_col);
  assign w_addr = w_full[AW-1:0];

  // The compute pipeline moves only when the output register can take a result.
  assign adv = !(out_valid_r && out_stall);

  smm_seq #(
    .MAX_DIM (MAX_DIM)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .adv    (adv),
    .rows   (rows_a_r),
    .inner  (inner_r),
    .cols   (cols_b_r),
    .busy   (busy),
    .tag    (seq_tag),
    .a_addr (a_addr),
    .b_addr (b_addr)
  );

  // Element stores: one write port for loads, one registered read port each.
  always_ff @(posedge clk) begin
    if (load_a) begin
      mem_a[w_addr] <= in_elem_value;
    end
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      mem_b[w_addr] <= in_elem_value;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_rd_r <= mem_a[a_addr];
      b_rd_r <= mem_b[b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
    end else if (adv) begin
      tag1_r <= seq_tag;
    end
  end

  smm_mac #(
    .MAX_DIM (MAX_DIM)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .a_val  (a_rd_r),
    .b_val  (b_rd_r),
    .tag_in (tag1_r),
    .res    (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.vld) begin
      out_row_r   <= res.row;
      out_col_r   <= res.col;
      out_value_r <= res.value;
      out_sat_r   <= res.sat;
      out_last_r  <= res.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_value     = out_value_r;
  assign out_saturated = out_sat_r;
  assign out_last      = out_last_r;

endmodule

[src/smm_seq.sv]
// Sequencer that walks row, column and inner index of a compute and issues store reads.
module smm_seq #(
  parameter int MAX_DIM = smm_pkg::MAX_DIM_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       adv,
  input  logic [smm_pkg::DIM_W-1:0]  rows,
  input  logic [smm_pkg::DIM_W-1:0]  inner,
  input  logic [smm_pkg::DIM_W-1:0]  cols,
  output logic                       busy,
  output smm_pkg::tag_t              tag,
  output logic [((MAX_DIM < smm_pkg::DIM_LIMIT ? MAX_DIM : smm_pkg::DIM_LIMIT) *
                 (MAX_DIM < smm_pkg::DIM_LIMIT ? MAX_DIM : smm_pkg::DIM_LIMIT) > 1 ?
                 $clog2((MAX_DIM < smm_pkg::DIM_LIMIT ? MAX_DIM : smm_pkg::DIM_LIMIT) *
                        (MAX_DIM < smm_pkg::DIM_LIMIT ? MAX_DIM : smm_pkg::DIM_LIMIT)) : 1)
                -1:0] a_addr,
  output logic [((MAX_DIM < smm_pkg::DIM_LIMIT ? MAX_DIM : smm_pkg::DIM_LIMIT) *
                 (MAX_DIM < smm_pkg::DIM_LIMIT ? MAX_DIM : smm_pkg::DIM_LIMIT) > 1 ?
                 $clog2((MAX_DIM < smm_pkg::DIM_LIMIT ? MAX_DIM : smm_pkg::DIM_LIMIT) *
                        (MAX_DIM < smm_pkg::DIM_LIMIT ? MAX_DIM : smm_pkg::DIM_LIMIT)) : 1)
                -1:0] b_addr
);

  localparam int DIM_CAP = (MAX_DIM < smm_pkg::DIM_LIMIT) ? MAX_DIM : smm_pkg::DIM_LIMIT;
  localparam int DEPTH   = DIM_CAP * DIM_CAP;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW      = 8;

  logic                      busy_r, busy_nxt;
  logic [smm_pkg::IDX_W-1:0] r_r, r_nxt;
  logic [smm_pkg::IDX_W-1:0] c_r, c_nxt;
  logic [smm_pkg::IDX_W-1:0] k_r, k_nxt;
  logic                      issue;
  logic                      k_end, c_end, r_end;
  logic [FW-1:0]             a_full, b_full;

  assign issue = busy_r && adv;
  assign k_end = ({1'b0, k_r} == inner - smm_pkg::DIM_W'(1));
  assign c_end = ({1'b0, c_r} == cols  - smm_pkg::DIM_W'(1));
  assign r_end = ({1'b0, r_r} == rows  - smm_pkg::DIM_W'(1));

  always_comb begin
    busy_nxt = busy_r;
    r_nxt    = r_r;
    c_nxt    = c_r;
    k_nxt    = k_r;
    if (start) begin
      busy_nxt = 1'b1;
      r_nxt    = '0;
      c_nxt    = '0;
      k_nxt    = '0;
    end else if (issue) begin
      if (k_end) begin
        k_nxt = '0;
        if (c_end) begin
          c_nxt = '0;
          if (r_end) begin
            busy_nxt = 1'b0;
          end else begin
            r_nxt = r_r + smm_pkg::IDX_W'(1);
          end
        end else begin
          c_nxt = c_r + smm_pkg::IDX_W'(1);
        end
      end else begin
        k_nxt = k_r + smm_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      r_r    <= '0;
      c_r    <= '0;
      k_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      r_r    <= r_nxt;
      c_r    <= c_nxt;
      k_r    <= k_nxt;
    end
  end

  // Row-major store layout: row times the dimension cap plus column.
  assign a_full = FW'(r_r) * FW'(DIM_CAP) + FW'(k_r);
  assign b_full = FW'(k_r) * FW'(DIM_CAP) + FW'(c_r);
  assign a_addr = a_full[AW-1:0];
  assign b_addr = b_full[AW-1:0];

  assign busy      = busy_r;
  assign tag.vld   = issue;
  assign tag.first = (k_r == '0);
  assign tag.lastk = k_end;
  assign tag.row   = r_r;
  assign tag.col   = c_r;
  assign tag.last  = k_end && c_end && r_end;

endmodule

[src/smm_mac.sv]
// Shared multiply-accumulate unit with the final shift and saturation.
module smm_mac #(
  parameter int MAX_DIM = smm_pkg::MAX_DIM_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic [smm_pkg::ELEM_W-1:0] a_val,
  input  logic [smm_pkg::ELEM_W-1:0] b_val,
  input  smm_pkg::tag_t              tag_in,
  output smm_pkg::res_t              res
);

  localparam int DIM_CAP = (MAX_DIM < smm_pkg::DIM_LIMIT) ? MAX_DIM : smm_pkg::DIM_LIMIT;
  localparam int ACC_W   = smm_pkg::PROD_W + $clog2(DIM_CAP) + 1;
  localparam int TOP_LO  = smm_pkg::FRAC_W + smm_pkg::ELEM_W - 1;

  logic signed [smm_pkg::PROD_W-1:0] prod_r;
  smm_pkg::tag_t                     tag2_r;
  logic signed [ACC_W-1:0]           acc_r;
  logic signed [ACC_W-1:0]           prod_ext;
  logic                              done_r;
  logic [smm_pkg::IDX_W-1:0]         row_r, col_r;
  logic                              last_r;
  logic [ACC_W-1-TOP_LO:0]           top_bits;
  logic                              fits;

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r <= '0;
    end else if (adv) begin
      tag2_r <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= $signed(a_val) * $signed(b_val);
    end
  end

  assign prod_ext = ACC_W'(prod_r);

  // Accumulate stage; done_r marks a finished sum held in acc_r.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else if (adv) begin
      done_r <= tag2_r.vld && tag2_r.lastk;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tag2_r.vld) begin
      acc_r  <= tag2_r.first ? prod_ext : acc_r + prod_ext;
      row_r  <= tag2_r.row;
      col_r  <= tag2_r.col;
      last_r <= tag2_r.last;
    end
  end

  // After the floor shift by 16, the sum fits 32 bits when every bit above bit 31
  // of the shifted value matches its sign.
  assign top_bits = acc_r[ACC_W-1:TOP_LO];
  assign fits     = (top_bits == '0) || (top_bits == '1);

  always_comb begin
    res.vld  = done_r;
    res.row  = row_r;
    res.col  = col_r;
    res.last = last_r;
    res.sat  = !fits;
    if (fits) begin
      res.value = acc_r[TOP_LO:smm_pkg::FRAC_W];
    end else if (acc_r[ACC_W-1]) begin
      res.value = {1'b1, {(smm_pkg::ELEM_W-1){1'b0}}};
    end else begin
      res.value = {1'b0, {(smm_pkg::ELEM_W-1){1'b1}}};
    end
  end

endmodule
